/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the grid smoother checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on an explicit clock and active-low reset
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assertion on the house clock and reset names
`define ASSERT_STD(label, prop, msg) `ASSERT_AT(label, clk_i, rst_ni, prop, msg)

`endif

/* rtl/nmgs_pkg.sv */
// ----------------------------------------------------------------------------
// nmgs_pkg
// Shared constants and types for the neighbor-mean grid smoother.
// ----------------------------------------------------------------------------
package nmgs_pkg;

  // Default sizes for the top-level parameters
  localparam int unsigned DEF_MAX_WIDTH   = 256;
  localparam int unsigned DEF_MAX_HEIGHT  = 512;
  localparam int unsigned DEF_SAMPLE_BITS = 16;

  // Configuration register layout
  localparam int unsigned WIDTH_REG_BITS  = 9;
  localparam int unsigned HEIGHT_REG_BITS = 10;
  localparam int unsigned CFG_DATA_BITS   = 10;
  localparam int unsigned CFG_IDX_BITS    = 2;
  localparam int unsigned WIDTH_RESET     = 210;
  localparam int unsigned HEIGHT_RESET    = 420;

  // Smallest grid side that the window logic supports
  localparam int unsigned MIN_SPAN = 3;

  // Result queue depth (power of two)
  localparam int unsigned FIFO_DEPTH = 4;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1
  } cfg_reg_e;

endpackage

/* rtl/nmgs_ram.sv */
// ----------------------------------------------------------------------------
// nmgs_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module nmgs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AddrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk_i,
  input  logic                wr_en_i,
  input  logic [AddrBits-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]    wr_data_i,
  input  logic                rd_en_i,
  input  logic [AddrBits-1:0] rd_addr_i,
  output logic [WIDTH-1:0]    rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Storage array and read register
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/nmgs_col_cell.sv */
// ----------------------------------------------------------------------------
// nmgs_col_cell
// One window column (top, middle, bottom sample) of the 3x3 window chain.
// Loads the column from its left neighbor on every advance.
// ----------------------------------------------------------------------------
module nmgs_col_cell #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             shift_i,
  input  logic [2:0][SAMPLE_BITS-1:0]      col_i,   // [0] top, [1] mid, [2] bottom
  output logic [2:0][SAMPLE_BITS-1:0]      col_o
);

  logic [2:0][SAMPLE_BITS-1:0] col_q;

  // Column register, advances with the window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (shift_i) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;

endmodule

/* rtl/nmgs_result_fifo.sv */
// ----------------------------------------------------------------------------
// nmgs_result_fifo
// Small result queue that takes zero, one or two entries per cycle and
// hands out one entry per transfer. The caller checks room via count_o.
// ----------------------------------------------------------------------------
module nmgs_result_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CntBits = $clog2(DEPTH + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [1:0]                 push_num_i,   // 0, 1 or 2 entries
  input  logic [1:0][WIDTH-1:0]      push_data_i,  // [0] goes out first
  output logic [CntBits-1:0]         count_o,
  output logic                       pop_valid_o,
  input  logic                       pop_ready_i,
  output logic [WIDTH-1:0]           pop_data_o
);

  logic [WIDTH-1:0]   entry_q [DEPTH];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr_nx;
  logic [CntBits-1:0] count_q, count_d;
  logic               pop;

  assign pop         = pop_valid_o && pop_ready_i;
  assign pop_valid_o = (count_q != '0);
  assign pop_data_o  = entry_q[rd_ptr_q];
  assign count_o     = count_q;
  assign wr_ptr_nx   = wr_ptr_q + PtrBits'(1);

  // Pointer and fill arithmetic
  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrBits'(push_num_i);
    rd_ptr_d = rd_ptr_q + PtrBits'(pop);
    count_d  = count_q + CntBits'(push_num_i) - CntBits'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry writes, second entry lands one slot after the first
  always_ff @(posedge clk_i) begin
    if (push_num_i != 2'd0) begin
      entry_q[wr_ptr_q] <= push_data_i[0];
    end
    if (push_num_i == 2'd2) begin
      entry_q[wr_ptr_nx] <= push_data_i[1];
    end
  end

endmodule

/* rtl/neighbour_mean_grid_smoother_core.sv */
// ----------------------------------------------------------------------------
// neighbour_mean_grid_smoother_core
// 3x3 neighbor-mean filter over a raster grid, center cell excluded.
// ----------------------------------------------------------------------------
// Samples stream in row-major order and are taken at one per clock while the
// result queue has room. Each interior cell is reported as the sum of its
// eight neighbors (the mean in eighths), or as its own sample times eight
// when that sum is zero; border cells come out as sample times eight. An
// interior cell is reported with the sample one row below and one column
// right of it; a border cell with its own sample. A sample causes 0, 1 or 2
// results; with two, the interior one comes first and only the second carries
// tlast. Each input transfer is registered in stage 1 and then in the result
// queue. The output port moves one result per cycle while the sink is ready,
// so the last column from row 2 on and the last row from column 2 on give two
// results per sample and hold back the input once the queue fills. Two line
// stores (one RAM, one read and one write per cycle) hold the two previous
// rows; a row of two column cells holds the left part of the window. Writing
// either size register restarts the frame at row 0, column 0; write only
// while no results are pending. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module neighbour_mean_grid_smoother_core #(
  parameter int unsigned MAX_WIDTH   = nmgs_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT  = nmgs_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned SAMPLE_BITS = nmgs_pkg::DEF_SAMPLE_BITS,
  localparam int unsigned COL_BITS      = $clog2(MAX_WIDTH),
  localparam int unsigned ROW_BITS      = $clog2(MAX_HEIGHT),
  localparam int unsigned VALUE_BITS    = SAMPLE_BITS + 3,
  localparam int unsigned IN_DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_DATA_BITS = ((ROW_BITS + COL_BITS + VALUE_BITS + 7) / 8) * 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [nmgs_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [nmgs_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  // sample stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [IN_DATA_BITS-1:0]           s_axis_tdata,   // depth
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [OUT_DATA_BITS-1:0]          m_axis_tdata,   // row, col, value
  output logic                              m_axis_tlast
);

  import nmgs_pkg::*;

  localparam int unsigned NUM_CELLS   = 2;
  localparam int unsigned RES_BITS    = 1 + VALUE_BITS + COL_BITS + ROW_BITS;
  localparam int unsigned FifoCntBits = $clog2(FIFO_DEPTH + 1);

  // Clamp a size to [MIN_SPAN, maxv] and return the last index
  function automatic logic [31:0] span_last(logic [31:0] v, logic [31:0] maxv);
    logic [31:0] lim;
    lim = v;
    if (lim < MIN_SPAN) lim = MIN_SPAN;
    if (lim > maxv) lim = maxv;
    return lim - 32'd1;
  endfunction

  function automatic logic signed [VALUE_BITS-1:0] sext(logic [SAMPLE_BITS-1:0] v);
    return VALUE_BITS'($signed(v));
  endfunction

  function automatic logic signed [VALUE_BITS-1:0] times8(logic [SAMPLE_BITS-1:0] v);
    return $signed({v, 3'b000});
  endfunction

  // Frame geometry and position
  logic [COL_BITS-1:0] last_col_q, col_q;
  logic [ROW_BITS-1:0] last_row_q, row_q;
  logic                cfg_fire, in_fire;

  // Stage 1: sample waiting for its line-store data
  logic                   s1_valid_q, s1_interior_q, s1_border_q;
  logic [ROW_BITS-1:0]    s1_row_q;
  logic [COL_BITS-1:0]    s1_col_q;
  logic [SAMPLE_BITS-1:0] s1_x_q;
  logic [1:0]             s1_n;
  logic                   s1_go;

  logic [2*SAMPLE_BITS-1:0] line_rd, line_wr;
  logic [SAMPLE_BITS-1:0]   above2, above1;

  logic [NUM_CELLS:0][2:0][SAMPLE_BITS-1:0] chain;

  logic signed [VALUE_BITS-1:0] sum, interior_val, border_val;
  logic [RES_BITS-1:0]          int_res, bord_res, fifo_out;
  logic [1:0]                   push_num;
  logic [1:0][RES_BITS-1:0]     push_data;
  logic [FifoCntBits-1:0]       fifo_count;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign in_fire     = s_axis_tvalid && s_axis_tready;

  // Stage 1 leaves once the queue has room for all its results
  assign s1_n  = {1'b0, s1_interior_q} + {1'b0, s1_border_q};
  assign s1_go = s1_valid_q && ((32'(fifo_count) + 32'(s1_n)) <= FIFO_DEPTH);
  assign s_axis_tready = !s1_valid_q || s1_go;

  // Size registers and raster position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_col_q <= COL_BITS'(span_last(WIDTH_RESET, MAX_WIDTH));
      last_row_q <= ROW_BITS'(span_last(HEIGHT_RESET, MAX_HEIGHT));
      col_q      <= '0;
      row_q      <= '0;
    end else if (cfg_fire) begin
      case (cfg_index_i)
        REG_WIDTH: begin
          last_col_q <= COL_BITS'(span_last(32'(cfg_data_i[WIDTH_REG_BITS-1:0]), MAX_WIDTH));
          col_q      <= '0;
          row_q      <= '0;
        end
        REG_HEIGHT: begin
          last_row_q <= ROW_BITS'(span_last(32'(cfg_data_i[HEIGHT_REG_BITS-1:0]), MAX_HEIGHT));
          col_q      <= '0;
          row_q      <= '0;
        end
        default: begin
        end
      endcase
    end else if (in_fire) begin
      if (col_q == last_col_q) begin
        col_q <= '0;
        row_q <= (row_q == last_row_q) ? '0 : row_q + ROW_BITS'(1);
      end else begin
        col_q <= col_q + COL_BITS'(1);
      end
    end
  end

  // Stage 1 control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      s1_interior_q <= 1'b0;
      s1_border_q   <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q    <= 1'b1;
      s1_interior_q <= (32'(row_q) >= 32'd2) && (32'(col_q) >= 32'd2);
      s1_border_q   <= (row_q == '0) || (row_q == last_row_q) ||
                       (col_q == '0) || (col_q == last_col_q);
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_row_q <= row_q;
      s1_col_q <= col_q;
      s1_x_q   <= s_axis_tdata[SAMPLE_BITS-1:0];
    end
  end

  // Line stores: low half is two rows up, high half is one row up
  assign above2  = line_rd[SAMPLE_BITS-1:0];
  assign above1  = line_rd[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign line_wr = {s1_x_q, above1};

  nmgs_ram #(
    .WIDTH (2 * SAMPLE_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i     (clk_i),
    .wr_en_i   (s1_go),
    .wr_addr_i (s1_col_q),
    .wr_data_i (line_wr),
    .rd_en_i   (in_fire),
    .rd_addr_i (col_q),
    .rd_data_o (line_rd)
  );

  // Window chain: cell 0 holds column c-1, cell 1 holds column c-2
  assign chain[0][0] = above2;
  assign chain[0][1] = above1;
  assign chain[0][2] = s1_x_q;

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    nmgs_col_cell #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (s1_go),
      .col_i   (chain[g]),
      .col_o   (chain[g+1])
    );
  end

  // Neighbor sum, center of the window left out
  assign sum = sext(chain[2][0]) + sext(chain[2][1]) + sext(chain[2][2])
             + sext(chain[1][0]) + sext(chain[1][2])
             + sext(above2) + sext(above1) + sext(s1_x_q);

  assign interior_val = (sum != '0) ? sum : times8(chain[1][1]);
  assign border_val   = times8(s1_x_q);

  // Result words: {last, value, col, row}
  assign int_res  = {!s1_border_q, interior_val, s1_col_q - COL_BITS'(1),
                     s1_row_q - ROW_BITS'(1)};
  assign bord_res = {1'b1, border_val, s1_col_q, s1_row_q};

  assign push_num     = s1_go ? s1_n : 2'd0;
  assign push_data[0] = s1_interior_q ? int_res : bord_res;
  assign push_data[1] = bord_res;

  nmgs_result_fifo #(
    .WIDTH (RES_BITS),
    .DEPTH (FIFO_DEPTH)
  ) u_result_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_num_i  (push_num),
    .push_data_i (push_data),
    .count_o     (fifo_count),
    .pop_valid_o (m_axis_tvalid),
    .pop_ready_i (m_axis_tready),
    .pop_data_o  (fifo_out)
  );

  assign m_axis_tdata = OUT_DATA_BITS'(fifo_out[RES_BITS-2:0]);
  assign m_axis_tlast = fifo_out[RES_BITS-1];

endmodule

/* rtl/nmgs_checker.sv */
// ----------------------------------------------------------------------------
// nmgs_checker
// Port-level checks for the grid smoother, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nmgs_checker #(
  parameter int unsigned MAX_WIDTH   = nmgs_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT  = nmgs_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned SAMPLE_BITS = nmgs_pkg::DEF_SAMPLE_BITS,
  localparam int unsigned COL_BITS      = $clog2(MAX_WIDTH),
  localparam int unsigned ROW_BITS      = $clog2(MAX_HEIGHT),
  localparam int unsigned VALUE_BITS    = SAMPLE_BITS + 3,
  localparam int unsigned OUT_DATA_BITS = ((ROW_BITS + COL_BITS + VALUE_BITS + 7) / 8) * 8
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     m_axis_tvalid,
  input logic                     m_axis_tready,
  input logic [OUT_DATA_BITS-1:0] m_axis_tdata,   // row, col, value
  input logic                     m_axis_tlast
);

  localparam int unsigned VAL_LSB = ROW_BITS + COL_BITS;

  logic row_zero, col_zero, val_scaled;

  assign row_zero   = (m_axis_tdata[ROW_BITS-1:0] == '0);
  assign col_zero   = (m_axis_tdata[VAL_LSB-1:ROW_BITS] == '0);
  assign val_scaled = (m_axis_tdata[VAL_LSB+2:VAL_LSB] == 3'b000);

  // A result offered must stay offered until its transfer
  `ASSERT_STD(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped")

  // Top row and left column are always border cells: sample times eight
  `ASSERT_STD(a_row0_border, m_axis_tvalid && row_zero |-> val_scaled, "row 0 not scaled")
  `ASSERT_STD(a_col0_border, m_axis_tvalid && col_zero |-> val_scaled, "col 0 not scaled")

  // A non-final result is an interior cell, never on row 0 or column 0
  `ASSERT_STD(a_first_interior, m_axis_tvalid && !m_axis_tlast |-> !row_zero && !col_zero, "bad first result")

  // The border result of a pair is queued with it and follows at once
  `ASSERT_STD(a_pair_follows, m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid && m_axis_tlast, "pair split")

endmodule

bind neighbour_mean_grid_smoother_core nmgs_checker #(
  .MAX_WIDTH   (MAX_WIDTH),
  .MAX_HEIGHT  (MAX_HEIGHT),
  .SAMPLE_BITS (SAMPLE_BITS)
) u_nmgs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

/* tb/neighbour_mean_grid_smoother_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighbour_mean_grid_smoother_core_tb
// Self-checking bench for the 3x3 neighbor-mean grid smoother.
// ----------------------------------------------------------------------------
// Streams grids of signed samples through the core and predicts every result
// cell (row, column, value in eighths, tlast) with a behavioral line-buffer
// model kept alongside. A scoreboard matches each output transfer against the
// oldest predicted cell. Directed frames cover the sample extremes and the
// zero-sum case; random phases then vary the grid size (clamped sizes too),
// restart frames mid-way through size writes and, in the first two random
// phases, apply random backpressure on both streams.
// ----------------------------------------------------------------------------
module neighbour_mean_grid_smoother_core_tb;

  import nmgs_pkg::*;

  localparam int unsigned ROW_W    = 9;
  localparam int unsigned COL_W    = 8;
  localparam int unsigned VAL_W    = DEF_SAMPLE_BITS + 3;
  localparam int unsigned IN_BITS  = ((DEF_SAMPLE_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS = ((ROW_W + COL_W + VAL_W + 7) / 8) * 8;
  localparam int unsigned GRID_MAX_W = DEF_MAX_WIDTH;
  localparam int unsigned GRID_MAX_H = DEF_MAX_HEIGHT;
  localparam int unsigned SETTLE_CYCLES = 8;

  // register indexes with no register behind them
  localparam logic [CFG_IDX_BITS-1:0] SPARE_REG_LO = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] SPARE_REG_HI = 2'd3;

  typedef enum int unsigned {FILL_RANDOM, FILL_EXTREME, FILL_SPARSE} fill_e;

  typedef struct packed {
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } cell_result_t;

  // DUT connections, all inputs known from time zero
  logic                      clk_i         = 1'b0;
  logic                      rst_ni        = 1'b0;
  logic                      cfg_valid_i   = 1'b0;
  logic                      cfg_ready_o;
  logic [CFG_IDX_BITS-1:0]   cfg_index_i   = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data_i    = '0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [IN_BITS-1:0]        s_axis_tdata  = '0;   // depth
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [OUT_BITS-1:0]       m_axis_tdata;         // row, col, value
  logic                      m_axis_tlast;

  neighbour_mean_grid_smoother_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Smoother model state
  // --------------------------------------------------------------------------
  logic [WIDTH_REG_BITS-1:0]  width_reg  = WIDTH_RESET;
  logic [HEIGHT_REG_BITS-1:0] height_reg = HEIGHT_RESET;
  logic signed [DEF_SAMPLE_BITS-1:0] above_far_row  [GRID_MAX_W];
  logic signed [DEF_SAMPLE_BITS-1:0] above_near_row [GRID_MAX_W];
  // [0..2] column c-1 (top, mid, bottom), [3..5] column c-2
  logic signed [DEF_SAMPLE_BITS-1:0] window_cols [6];
  int unsigned cur_row = 0;
  int unsigned cur_col = 0;

  cell_result_t pending_cells [$];
  int unsigned  mismatch_count = 0;
  int unsigned  src_idle_pct  = 0;
  int unsigned  sink_idle_pct = 0;

  initial begin
    foreach (above_far_row[i]) begin
      above_far_row[i]  = '0;
      above_near_row[i] = '0;
    end
    foreach (window_cols[i]) window_cols[i] = '0;
  end

  function automatic int unsigned span_clamp(input int unsigned v, input int unsigned hi);
    if (v < MIN_SPAN) return MIN_SPAN;
    if (v > hi) return hi;
    return v;
  endfunction

  // Size register write; a real register also restarts the frame
  function automatic void apply_reg_write(input logic [CFG_IDX_BITS-1:0] idx,
                                          input logic [CFG_DATA_BITS-1:0] data);
    case (idx)
      REG_WIDTH: begin
        width_reg = data[WIDTH_REG_BITS-1:0];
        cur_row = 0;
        cur_col = 0;
      end
      REG_HEIGHT: begin
        height_reg = data[HEIGHT_REG_BITS-1:0];
        cur_row = 0;
        cur_col = 0;
      end
      default: ;
    endcase
  endfunction

  // Predict the cells one accepted sample releases and advance the window
  task automatic smooth_sample(input logic signed [DEF_SAMPLE_BITS-1:0] d);
    int unsigned aw, ah, r, c;
    logic signed [DEF_SAMPLE_BITS-1:0] far_px, near_px;
    int           sum;
    cell_result_t cells [$];
    cell_result_t res_item;
    aw = span_clamp(width_reg, GRID_MAX_W);
    ah = span_clamp(height_reg, GRID_MAX_H);
    r = cur_row;
    c = cur_col;
    if (c >= aw) c = 0;
    if (r >= ah) r = 0;
    far_px  = above_far_row[c];
    near_px = above_near_row[c];

    // interior cell one up and one left, window now complete
    if (r >= 2 && c >= 2) begin
      sum = window_cols[3] + window_cols[0] + far_px + window_cols[4] + near_px
          + window_cols[5] + window_cols[2] + d;
      res_item.row   = ROW_W'(r - 1);
      res_item.col   = COL_W'(c - 1);
      res_item.value = (sum != 0) ? VAL_W'(sum) : VAL_W'(int'(window_cols[1]) * 8);
      res_item.last  = 1'b0;
      cells.push_back(res_item);
    end
    // border cell passes straight through
    if (r == 0 || r == ah - 1 || c == 0 || c == aw - 1) begin
      res_item.row   = ROW_W'(r);
      res_item.col   = COL_W'(c);
      res_item.value = VAL_W'(int'(d) * 8);
      res_item.last  = 1'b0;
      cells.push_back(res_item);
    end
    if (cells.size() > 0) cells[cells.size()-1].last = 1'b1;
    foreach (cells[i]) pending_cells.push_back(cells[i]);

    above_far_row[c]  = near_px;
    above_near_row[c] = d;
    window_cols[3] = window_cols[0];
    window_cols[4] = window_cols[1];
    window_cols[5] = window_cols[2];
    window_cols[0] = far_px;
    window_cols[1] = near_px;
    window_cols[2] = d;

    c++;
    if (c >= aw) begin
      c = 0;
      r++;
      if (r >= ah) r = 0;
    end
    cur_col = c;
    cur_row = r;
  endtask

  // --------------------------------------------------------------------------
  // Result sink: random backpressure and scoreboard
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cell_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.row   = m_axis_tdata[ROW_W-1:0];
      got.col   = m_axis_tdata[ROW_W+COL_W-1:ROW_W];
      got.value = m_axis_tdata[ROW_W+COL_W+VAL_W-1:ROW_W+COL_W];
      got.last  = m_axis_tlast;
      if (pending_cells.size() == 0) begin
        mismatch_count++;
        $display("%0t: extra transfer, exp none, act r %0d c %0d v %0d last %0b",
                 $time, got.row, got.col, $signed(got.value), got.last);
      end else begin
        want = pending_cells.pop_front();
        if (got.row !== want.row || got.col !== want.col ||
            got.value !== want.value || got.last !== want.last) begin
          mismatch_count++;
          $display("%0t: exp r %0d c %0d v %0d last %0b, act r %0d c %0d v %0d last %0b",
                   $time, want.row, want.col, $signed(want.value), want.last,
                   got.row, got.col, $signed(got.value), got.last);
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // One sample transfer, with a random gap ahead of it
  task automatic send_sample(input logic signed [DEF_SAMPLE_BITS-1:0] d);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_BITS'(d);
    do @(posedge clk_i); while (!s_axis_tready);
    smooth_sample(d);
  endtask

  // Stop the sample stream, drain every result, then let the pipe settle
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_cells.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg_write(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic signed [DEF_SAMPLE_BITS-1:0] pick_depth(input fill_e mode);
    case (mode)
      FILL_EXTREME: begin
        case ($urandom_range(4))
          0: return 16'sh8000;
          1: return 16'sh7FFF;
          2: return 16'sh0000;
          3: return 16'shFFFF;
          default: return 16'sh0001;
        endcase
      end
      FILL_SPARSE: begin
        if ($urandom_range(99) < 85) return '0;
        return 16'($urandom_range(16)) - 16'd8;
      end
      default: return 16'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset sizes: first row cells pass through scaled
  task automatic test_reset_size();
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
  endtask

  // Smallest grid: zero neighbor sum, then all-max and all-min frames
  task automatic test_smallest_grid();
    logic signed [DEF_SAMPLE_BITS-1:0] zero_sum_frame [9];
    zero_sum_frame = '{16'sd5, -16'sd5, 16'sd7, -16'sd7, 16'sd1234, 16'sd100,
                       -16'sd100, 16'sd1, -16'sd1};
    quiesce();
    write_reg(REG_WIDTH, CFG_DATA_BITS'(MIN_SPAN));
    write_reg(REG_HEIGHT, CFG_DATA_BITS'(MIN_SPAN));
    foreach (zero_sum_frame[i]) send_sample(zero_sum_frame[i]);
    repeat (9) send_sample(16'sh7FFF);
    repeat (9) send_sample(16'sh8000);
  endtask

  // Widest grid: width above the limit and height below it, one full frame and the start of the next
  task automatic test_widest_grid();
    quiesce();
    write_reg(REG_WIDTH, CFG_DATA_BITS'(511));
    write_reg(REG_HEIGHT, CFG_DATA_BITS'(0));
    repeat (GRID_MAX_W * MIN_SPAN + 5) send_sample(pick_depth(FILL_RANDOM));
  endtask

  // Tallest grid: width below the limit and height above it, first rows only
  task automatic test_tallest_grid();
    quiesce();
    write_reg(REG_WIDTH, CFG_DATA_BITS'(0));
    write_reg(REG_HEIGHT, CFG_DATA_BITS'(1023));
    repeat (MIN_SPAN * 128 + 5) send_sample(pick_depth(FILL_RANDOM));
  endtask

  // Random sizes and content; each phase sends a random number of samples and may stop mid-frame
  task automatic test_random_grids(input int unsigned n_items);
    int unsigned sent, w, h, frame, lim, chunk;
    fill_e mode;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(9))
        0:       w = $urandom_range(2);
        1:       w = $urandom_range(40, 13);
        2:       w = $urandom_range(511, 257);
        default: w = $urandom_range(12, 3);
      endcase
      case ($urandom_range(9))
        0:       h = $urandom_range(2);
        1:       h = $urandom_range(24, 13);
        2:       h = $urandom_range(1023, 513);
        default: h = $urandom_range(10, 3);
      endcase
      quiesce();
      case ($urandom_range(9))
        // no register behind the index, frame carries on
        0: write_reg($urandom_range(1) ? SPARE_REG_LO : SPARE_REG_HI,
                     CFG_DATA_BITS'($urandom));
        1: write_reg(REG_WIDTH, {1'($urandom_range(1)), 9'(w)});
        2: write_reg(REG_HEIGHT, CFG_DATA_BITS'(h));
        default: begin
          write_reg(REG_WIDTH, {1'($urandom_range(1)), 9'(w)});
          write_reg(REG_HEIGHT, CFG_DATA_BITS'(h));
        end
      endcase
      case ($urandom_range(5))
        0:       mode = FILL_EXTREME;
        1:       mode = FILL_SPARSE;
        default: mode = FILL_RANDOM;
      endcase
      frame = span_clamp(width_reg, GRID_MAX_W) * span_clamp(height_reg, GRID_MAX_H);
      lim   = 2 * frame + span_clamp(width_reg, GRID_MAX_W);
      if (lim > 250) lim = 250;
      chunk = $urandom_range(lim, 1);
      repeat (chunk) send_sample(pick_depth(mode));
      sent += chunk;
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    src_idle_pct  = 36;
    sink_idle_pct = 46;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_size();
    test_smallest_grid();
    test_random_grids(180);
    test_widest_grid();

    src_idle_pct  = 46;
    sink_idle_pct = 36;
    test_random_grids(180);
    test_tallest_grid();

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random_grids(180);

    quiesce();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
